### sv/byte_stuffed_frame_decoder_top_macros.svh
// Assertion macros for the byte-stuffed frame decoder.
// Included by the top level; depends on nothing else.
`ifndef BYTE_STUFFED_FRAME_DECODER_TOP_MACROS_SVH
`define BYTE_STUFFED_FRAME_DECODER_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define BSFD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define BSFD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/bsfd_pkg.sv
// Shared types and constants of the byte-stuffed frame decoder.
// Used by the front, queue, back and top modules; no dependencies.
package bsfd_pkg;

	// Escape codes that stand for the start, end and escape bytes.
	localparam logic [7:0] CODE_START = 8'h00;
	localparam logic [7:0] CODE_END   = 8'h01;
	localparam logic [7:0] CODE_ESC   = 8'h02;

	// Configuration register indexes.
	localparam logic [1:0] REG_START  = 2'd0;
	localparam logic [1:0] REG_END    = 2'd1;
	localparam logic [1:0] REG_ESCAPE = 2'd2;

	// Command queue between front and back.
	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QLVL_W  = $clog2(QDEPTH + 1);

	typedef enum logic [1:0] {
		CMD_OPEN  = 2'd0,
		CMD_PUSH  = 2'd1,
		CMD_CLOSE = 2'd2,
		CMD_FAIL  = 2'd3
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t    op;
		logic [7:0] data;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	typedef struct packed {
		logic [7:0]  length_code;
		logic [15:0] target_distance;
		logic [15:0] target_speed;
		logic [15:0] pitch_offset;
		logic [15:0] yaw_offset;
		logic        frame_ok;
	} result_t;

endpackage

### sv/byte_stuffed_frame_decoder_top.sv
// Byte-stuffed frame decoder: received bytes in, one decoded frame word out.
// Uses bsfd_pkg, bsfd_front, bsfd_queue, bsfd_back and the assertion macros.
//
// Usage:
// Raw serial bytes enter on the s_axis channel, one word per byte. The block
// hunts for the start byte, collects the body until the end byte and then
// delivers one result word on m_axis. An escape byte followed by 0, 1 or 2
// stands for a literal start, end or escape byte; any other code after an
// escape is kept as data. A frame is good when its last body byte equals the
// number of body bytes before it. A body longer than FRAME_BYTES-2 bytes gives
// a failure word with all fields zero, and the block hunts for a start again.
// Throughput is one byte per clock while the queue has room. An end byte's
// command goes into the command queue, then its result word into the result
// register that drives m_axis. While the receiver holds m_tready low with a
// word waiting, the back stops at the next end or failure command in the
// four-entry command queue; bytes are still taken until the queue is full, and
// then s_tready drops. Reset brings the registers to start 0x7E, end 0x7F,
// escape 0x7D and the decoder to hunting. Registers are to be written on
// cfg_we only while the block is idle; the block itself does not enforce it.
`include "byte_stuffed_frame_decoder_top_macros.svh"

module byte_stuffed_frame_decoder_top
	import bsfd_pkg::*;
#(
	parameter int FRAME_BYTES = 11
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream; tdata: rx_byte[7:0].
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,
	// Result stream; tdata from bit 0: frame_ok, yaw_offset[16], pitch_offset[16],
	// target_speed[16], target_distance[16], length_code[8], zero padding[7].
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,
	// Register write port.
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_wdata
);

	logic [7:0] start_q;
	logic [7:0] end_q;
	logic [7:0] escape_q;

	logic      q_push;
	logic      q_pop;
	cmd_t      front_cmd;
	cmd_t      q_head;
	q_status_t q_status;
	result_t   result;

	// Configuration registers; a write to an unused index is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q  <= 8'h7E;
			end_q    <= 8'h7F;
			escape_q <= 8'h7D;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_START:  start_q  <= cfg_wdata;
				REG_END:    end_q    <= cfg_wdata;
				REG_ESCAPE: escape_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// The front decides framing per byte and turns it into commands.
	bsfd_front #(
		.FRAME_BYTES (FRAME_BYTES)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.rx_byte     (s_tdata),
		.start_byte  (start_q),
		.end_byte    (end_q),
		.escape_byte (escape_q),
		.q_status    (q_status),
		.push        (q_push),
		.cmd         (front_cmd)
	);

	bsfd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (front_cmd),
		.pop      (q_pop),
		.head     (q_head),
		.status   (q_status)
	);

	// The back gathers body bytes and owns the result register, so a stalled
	// receiver only holds back result commands.
	bsfd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (q_head),
		.head_valid (!q_status.empty),
		.pop        (q_pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_result (result)
	);

	assign m_tdata = {7'd0, result};

	`BSFD_ASSERT_NOW(a_no_pop_empty, clk, arst_n, q_pop, !q_status.empty,
		"command popped from an empty queue")
	`BSFD_ASSERT_NOW(a_no_push_full, clk, arst_n, q_push, !q_status.full,
		"command pushed into a full queue")
	`BSFD_ASSERT_NOW(a_ok_length, clk, arst_n, m_tvalid && result.frame_ok,
		result.length_code < 8'(FRAME_BYTES - 2),
		"good frame with a length code beyond the body size")
	`BSFD_ASSERT_NEXT(a_push_fills, clk, arst_n, q_push && !q_pop, !q_status.empty,
		"queue empty after a push without a pop")

endmodule

### sv/bsfd_front.sv
// Front part: takes raw bytes, tracks framing and escapes, issues commands.
// Depends on bsfd_pkg.
module bsfd_front
	import bsfd_pkg::*;
#(
	parameter int FRAME_BYTES = 11
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	input  logic [7:0] start_byte,
	input  logic [7:0] end_byte,
	input  logic [7:0] escape_byte,
	input  q_status_t  q_status,
	output logic       push,
	output cmd_t       cmd
);

	localparam int BODY_MAX = FRAME_BYTES - 2;

	logic       in_frame_q;
	logic       esc_q;
	logic [3:0] count_q;

	logic       take;
	logic       gen;
	logic       in_frame_d;
	logic       esc_d;
	logic [3:0] count_d;
	logic [7:0] lit;
	logic       is_body;

	assign in_ready = !q_status.full;
	assign take     = in_valid && in_ready;

	always_comb begin
		lit = rx_byte;
		if (esc_q) begin
			if (rx_byte == CODE_START) begin
				lit = start_byte;
			end else if (rx_byte == CODE_END) begin
				lit = end_byte;
			end else if (rx_byte == CODE_ESC) begin
				lit = escape_byte;
			end
		end
	end

	always_comb begin
		gen        = 1'b0;
		cmd.op     = CMD_PUSH;
		cmd.data   = lit;
		in_frame_d = in_frame_q;
		esc_d      = esc_q;
		count_d    = count_q;
		is_body    = 1'b0;
		if (!in_frame_q) begin
			if (rx_byte == start_byte) begin
				gen        = 1'b1;
				cmd.op     = CMD_OPEN;
				in_frame_d = 1'b1;
				esc_d      = 1'b0;
				count_d    = '0;
			end
		end else if (esc_q) begin
			esc_d   = 1'b0;
			is_body = 1'b1;
		end else if (rx_byte == start_byte) begin
			gen     = 1'b1;
			cmd.op  = CMD_OPEN;
			count_d = '0;
		end else if (rx_byte == end_byte) begin
			gen        = 1'b1;
			cmd.op     = CMD_CLOSE;
			in_frame_d = 1'b0;
		end else if (rx_byte == escape_byte) begin
			esc_d = 1'b1;
		end else begin
			is_body = 1'b1;
		end

		if (is_body) begin
			gen = 1'b1;
			if (count_q >= 4'(BODY_MAX)) begin
				cmd.op     = CMD_FAIL;
				in_frame_d = 1'b0;
				esc_d      = 1'b0;
			end else begin
				cmd.op  = CMD_PUSH;
				count_d = count_q + 4'd1;
			end
		end
	end

	assign push = take && gen;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			esc_q      <= 1'b0;
			count_q    <= '0;
		end else if (take) begin
			in_frame_q <= in_frame_d;
			esc_q      <= esc_d;
			count_q    <= count_d;
		end
	end

endmodule

### sv/bsfd_queue.sv
// Short command queue that decouples the front from the back.
// Depends on bsfd_pkg.
module bsfd_queue
	import bsfd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  cmd_t      push_cmd,
	input  logic      pop,
	output cmd_t      head,
	output q_status_t status
);

	cmd_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QLVL_W-1:0] level_q;

	assign status.full  = (level_q == QLVL_W'(QDEPTH));
	assign status.empty = (level_q == '0);
	assign head         = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			level_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				level_q <= level_q + QLVL_W'(1);
			end else if (pop && !push) begin
				level_q <= level_q - QLVL_W'(1);
			end
		end
	end

endmodule

### sv/bsfd_back.sv
// Back part: executes commands, gathers body bytes, holds the result register.
// Depends on bsfd_pkg.
module bsfd_back
	import bsfd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  cmd_t    head,
	input  logic    head_valid,
	output logic    pop,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_result
);

	logic [7:0] field_q [8];
	logic [7:0] last_q;
	logic [3:0] count_q;
	logic       out_valid_q;
	result_t    out_result_q;

	logic    is_result;
	logic    out_free;
	logic    ok;
	result_t res;

	assign is_result = (head.op == CMD_CLOSE) || (head.op == CMD_FAIL);
	assign out_free  = !out_valid_q || out_ready;
	assign pop       = head_valid && (!is_result || out_free);
	assign ok        = (count_q != 4'd0) && (last_q == {4'd0, count_q - 4'd1});

	always_comb begin
		res = '0;
		if (head.op == CMD_CLOSE) begin
			res.frame_ok        = ok;
			res.yaw_offset      = {field_q[0], field_q[1]};
			res.pitch_offset    = {field_q[2], field_q[3]};
			res.target_speed    = {field_q[4], field_q[5]};
			res.target_distance = {field_q[6], field_q[7]};
			res.length_code     = last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			count_q     <= '0;
			last_q      <= '0;
			for (int i = 0; i < 8; i++) begin
				field_q[i] <= '0;
			end
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				unique case (head.op)
					CMD_OPEN: begin
						count_q <= '0;
						last_q  <= '0;
						for (int i = 0; i < 8; i++) begin
							field_q[i] <= '0;
						end
					end
					CMD_PUSH: begin
						if (count_q < 4'd8) begin
							field_q[count_q[2:0]] <= head.data;
						end
						last_q  <= head.data;
						count_q <= count_q + 4'd1;
					end
					CMD_CLOSE, CMD_FAIL: begin
						out_valid_q <= 1'b1;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && is_result) begin
			out_result_q <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_result = out_result_q;

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for byte_stuffed_frame_decoder_top: raw bytes in, frame words out.
// Needs bsfd_pkg and the decoder RTL; a scoreboard class predicts every frame word.
module tb_top;
	import bsfd_pkg::*;

	localparam int FRAME_BYTES = 11;
	localparam int BODY_MAX = FRAME_BYTES - 2;
	// Queue depth plus pipeline plus margin, for bytes that leave no word behind.
	localparam int SETTLE_CYCLES = 24;
	localparam int BYTES_TARGET = 1100;
	localparam int NUM_PHASES = 9;
	localparam int TIMEOUT_NS = 1_000_000;

	// Scoreboard: keeps its own copy of the registers and the deframer state,
	// predicts the frame word caused by each accepted byte and checks the
	// words that come out against the oldest prediction.
	class deframe_predictor;
		logic [7:0] start_val;
		logic [7:0] end_val;
		logic [7:0] esc_val;
		bit in_frame;
		bit esc_pending;
		int unsigned body_len;
		logic [7:0] body_head[8];
		logic [7:0] last_body;
		result_t frames_due[$];
		int unsigned errors;

		function new();
			start_val = 8'h7E;
			end_val = 8'h7F;
			esc_val = 8'h7D;
			errors = 0;
			open_frame();
			in_frame = 1'b0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [7:0] val);
			case (idx)
				REG_START: start_val = val;
				REG_END: end_val = val;
				REG_ESCAPE: esc_val = val;
				default: ;
			endcase
		endfunction

		function void open_frame();
			in_frame = 1'b1;
			esc_pending = 1'b0;
			body_len = 0;
			last_body = 8'h00;
			foreach (body_head[i])
				body_head[i] = 8'h00;
		endfunction

		// One decoded body byte; a byte past the buffer fails the frame.
		function void add_body(logic [7:0] b);
			result_t fail_word;
			if (body_len >= BODY_MAX) begin
				fail_word = '0;
				frames_due.push_back(fail_word);
				in_frame = 1'b0;
				esc_pending = 1'b0;
			end else begin
				if (body_len < 8)
					body_head[body_len] = b;
				last_body = b;
				body_len++;
			end
		endfunction

		function void take_byte(logic [7:0] b);
			logic [7:0] lit;
			result_t word;
			if (!in_frame) begin
				if (b == start_val)
					open_frame();
			end else if (esc_pending) begin
				// The byte after an escape is always data.
				esc_pending = 1'b0;
				case (b)
					CODE_START: lit = start_val;
					CODE_END: lit = end_val;
					CODE_ESC: lit = esc_val;
					default: lit = b;
				endcase
				add_body(lit);
			end else if (b == start_val) begin
				open_frame();
			end else if (b == end_val) begin
				word.frame_ok = (body_len != 0) && (last_body == body_len - 1);
				word.yaw_offset = {body_head[0], body_head[1]};
				word.pitch_offset = {body_head[2], body_head[3]};
				word.target_speed = {body_head[4], body_head[5]};
				word.target_distance = {body_head[6], body_head[7]};
				word.length_code = last_body;
				frames_due.push_back(word);
				in_frame = 1'b0;
				esc_pending = 1'b0;
			end else if (b == esc_val) begin
				esc_pending = 1'b1;
			end else begin
				add_body(b);
			end
		endfunction

		function void check_field(string field, logic [15:0] want_v, logic [15:0] got_v);
			if (got_v !== want_v) begin
				$error("%s: expected 0x%0h, got 0x%0h", field, want_v, got_v);
				errors++;
			end
		endfunction

		function void check_frame_word(logic [79:0] w);
			result_t want;
			result_t got;
			if (frames_due.size() == 0) begin
				$error("frame word 0x%0h arrived with no frame outstanding", w);
				errors++;
			end else begin
				want = frames_due.pop_front();
				got = w[$bits(result_t)-1:0];
				check_field("frame_ok", want.frame_ok, got.frame_ok);
				check_field("yaw_offset", want.yaw_offset, got.yaw_offset);
				check_field("pitch_offset", want.pitch_offset, got.pitch_offset);
				check_field("target_speed", want.target_speed, got.target_speed);
				check_field("target_distance", want.target_distance, got.target_distance);
				check_field("length_code", want.length_code, got.length_code);
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	// tdata: rx_byte[7:0].
	logic [7:0]  s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	// tdata from bit 0: frame_ok, yaw_offset, pitch_offset, target_speed,
	// target_distance, length_code, zero padding.
	logic [79:0] m_tdata;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [7:0]  cfg_wdata;

	deframe_predictor pred = new();
	// Stretches with no idling on either side.
	bit src_quiet = 1'b0;
	bit sink_quiet = 1'b0;
	// Every byte that the decoder accepts, including bytes ignored while hunting.
	int unsigned bytes_sent = 0;

	byte_stuffed_frame_decoder_top #(
		.FRAME_BYTES(FRAME_BYTES)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #1 clk = ~clk;

	// Offers one byte after a random gap and holds it until the decoder takes it.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = src_quiet ? 0 : $urandom_range(0, 9);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		do @(posedge clk); while (s_tready !== 1'b1);
		bytes_sent++;
		pred.take_byte(b);
	endtask

	// Sends a body byte, stuffed when it collides with one of the register values.
	task automatic put_body(input logic [7:0] b);
		if (b == pred.start_val) begin
			send_byte(pred.esc_val);
			send_byte(CODE_START);
		end else if (b == pred.end_val) begin
			send_byte(pred.esc_val);
			send_byte(CODE_END);
		end else if (b == pred.esc_val) begin
			send_byte(pred.esc_val);
			send_byte(CODE_ESC);
		end else begin
			send_byte(b);
		end
	endtask

	// Random byte, weighted toward the register values, the escape codes and 0xFF.
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 15))
			0: return pred.start_val;
			1: return pred.end_val;
			2: return pred.esc_val;
			3: return 8'($urandom_range(0, 2));
			4: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	// Mostly well-formed frames with random content and a matching length byte;
	// the rest is line noise, empty and overlong bodies, restarts, raw escape
	// codes and frames whose end byte never comes.
	task automatic send_random_frame();
		int kind;
		int body_n;
		logic [7:0] b;
		kind = $urandom_range(0, 99);
		src_quiet = ($urandom_range(0, 4) == 0);
		repeat ($urandom_range(0, 2)) send_byte(pick_byte());
		if (kind < 6) begin
			repeat ($urandom_range(1, 8)) send_byte(pick_byte());
		end else begin
			if (kind < 14)
				body_n = $urandom_range(BODY_MAX + 1, BODY_MAX + 3);
			else if (kind < 18)
				body_n = 0;
			else
				body_n = $urandom_range(1, BODY_MAX);
			send_byte(pred.start_val);
			for (int i = 0; i < body_n; i++) begin
				if (i == body_n - 1 && $urandom_range(0, 9) < 7)
					b = 8'(body_n - 1);
				else
					b = pick_byte();
				if ($urandom_range(0, 24) == 0) begin
					// Escape followed by an unstuffed byte.
					send_byte(pred.esc_val);
					send_byte(b);
				end else if ($urandom_range(0, 39) == 0) begin
					send_byte(pred.start_val);
				end else begin
					put_body(b);
				end
			end
			if (kind < 18 || kind >= 22)
				send_byte(pred.end_val);
		end
	endtask

	// Stops offering bytes until every predicted word is out, then lets the
	// command queue drain of bytes that give no word.
	task automatic settle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pred.frames_due.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		pred.set_reg(idx, val);
		@(posedge clk);
	endtask

	// Receiver: stalls a random number of cycles before each word, with
	// occasional stretches of back-to-back acceptance.
	initial begin
		int stall;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		stall = $urandom_range(0, 9);
		forever begin
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (m_tvalid !== 1'b1);
			pred.check_frame_word(m_tdata);
			if ($urandom_range(0, 15) == 0)
				sink_quiet = !sink_quiet;
			stall = sink_quiet ? 0 : $urandom_range(0, 9);
		end
	end

	initial begin
		logic [7:0] directed[$];
		logic [7:0] s_val;
		logic [7:0] e_val;
		logic [7:0] x_val;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= 8'h00;
		cfg_we <= 1'b0;
		cfg_index <= REG_START;
		cfg_wdata <= 8'h00;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed bytes under the reset register values (start 7E, end 7F, escape 7D).
		directed = '{
			// An end byte while hunting is ignored.
			8'h7F,
			// Empty body: a failed frame with all fields zero.
			8'h7E, 8'h7F,
			// Stuffed start, escape and end bytes, an unknown escape code kept
			// as data and a matching length byte; body bytes 6 to 8 are missing.
			8'h7E, 8'h7D, 8'h00, 8'h7D, 8'h02, 8'h7D, 8'h01, 8'h7D, 8'hFF, 8'h04, 8'h7F,
			// A start byte inside a frame restarts it; one-byte body {00} is good.
			8'h7E, 8'h11, 8'h7E, 8'h00, 8'h7F,
			// Overlong body: the tenth byte fails the frame and the end byte
			// that follows is ignored while hunting.
			8'h7E, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
			8'h7F
		};
		foreach (directed[i])
			send_byte(directed[i]);

		// Each phase runs under its own register setting, written while idle.
		for (int p = 0; p < NUM_PHASES; p++) begin
			if (p != 0) begin
				settle();
				case (p)
					1: begin s_val = 8'h00; e_val = 8'hFF; x_val = 8'h80; end
					2: begin s_val = 8'hFF; e_val = 8'h00; x_val = 8'h01; end
					// Register values equal to the escape codes.
					3: begin s_val = 8'h01; e_val = 8'h02; x_val = 8'h00; end
					// All three equal: a start byte wins, frames only end overlong.
					4: begin s_val = 8'h5A; e_val = 8'h5A; x_val = 8'h5A; end
					5: begin s_val = 8'h33; e_val = 8'h33; x_val = 8'h44; end
					6: begin s_val = 8'h10; e_val = 8'h20; x_val = 8'h20; end
					8: begin s_val = 8'h7E; e_val = 8'h7F; x_val = 8'h7D; end
					default: begin
						s_val = 8'($urandom);
						e_val = 8'($urandom);
						x_val = 8'($urandom);
					end
				endcase
				write_reg(REG_START, s_val);
				write_reg(REG_END, e_val);
				write_reg(REG_ESCAPE, x_val);
			end
			while (bytes_sent < BYTES_TARGET * (p + 1) / NUM_PHASES) begin
				send_random_frame();
				// Now and then the sender holds off until every word is out.
				if ($urandom_range(0, 29) == 0)
					settle();
			end
		end

		settle();
		if (pred.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Hang guard, far beyond the slowest legal run.
	initial begin
		#(TIMEOUT_NS);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

### filelist.f
+incdir+sv
sv/bsfd_pkg.sv
sv/bsfd_front.sv
sv/bsfd_queue.sv
sv/bsfd_back.sv
sv/byte_stuffed_frame_decoder_top.sv
bench/tb_top.sv
